[hdl/shsq_pkg.sv]
// shsq_pkg: types, codes and constants of the half-step job sequencer.
// No dependencies; used by shsq_div and the top level.
`timescale 1ns / 1ps

package shsq_pkg;

  localparam int unsigned HswW     = 10;
  localparam int unsigned ThrW     = 15;
  localparam int unsigned CfgDataW = 15;
  localparam int unsigned DelayW   = 13;
  localparam int unsigned QuotW    = 14;
  localparam int unsigned DivisorW = 17;

  localparam logic [QuotW-1:0]  Dividend   = 14'd10000;
  localparam logic [DelayW-1:0] DelayMax   = 13'd8191;
  localparam logic [3:0]        PhaseNone  = 4'd8;
  localparam logic [3:0]        PhaseLast  = 4'd7;
  localparam logic [HswW-1:0]   HswReset   = 10'd2;
  localparam logic [ThrW-1:0]   ThrReset   = 15'd100;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd3
  } dir_e;

  typedef enum logic {
    CFG_HALF_STEP_WAIT  = 1'b0,
    CFG_SPEED_THRESHOLD = 1'b1
  } cfg_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DIV  = 1'b1
  } state_e;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] speed;
    logic [15:0]        distance;
  } req_t;

  typedef struct packed {
    logic [3:0] coil_pattern;
    logic       coil_update;
    logic       busy_res;
    logic       rejected;
  } res_t;

  function automatic logic [3:0] pattern(input logic [2:0] idx);
    logic [3:0] p;
    case (idx)
      3'd0:    p = 4'h1;
      3'd1:    p = 4'h3;
      3'd2:    p = 4'h2;
      3'd3:    p = 4'h6;
      3'd4:    p = 4'h4;
      3'd5:    p = 4'hc;
      3'd6:    p = 4'h8;
      default: p = 4'h9;
    endcase
    return p;
  endfunction

endpackage

[hdl/shsq_div.sv]
// shsq_div: serial restoring divider, constant dividend over a 17-bit divisor.
// One quotient bit per cycle. Depends on shsq_pkg.
`timescale 1ns / 1ps

module shsq_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [shsq_pkg::DivisorW-1:0]   divisor_i,
  output logic                            done_o,
  output logic [shsq_pkg::QuotW-1:0]      quot_o
);

  localparam int unsigned CntW = $clog2(shsq_pkg::QuotW);
  localparam logic [CntW-1:0] CntLast = CntW'(shsq_pkg::QuotW - 1);

  logic                          run_q, run_d;
  logic                          done_q, done_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [shsq_pkg::DivisorW-1:0] div_q, div_d;
  logic [shsq_pkg::DivisorW-1:0] rem_q, rem_d;
  logic [shsq_pkg::QuotW-1:0]    quot_q, quot_d;
  logic [shsq_pkg::DivisorW:0]   trial;
  logic                          ge;

  assign trial = {rem_q, quot_q[shsq_pkg::QuotW-1]};
  assign ge    = trial >= {1'b0, div_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = '0;
      div_d  = divisor_i;
      rem_d  = '0;
      quot_d = shsq_pkg::Dividend;
    end else if (run_q) begin
      rem_d  = ge ? shsq_pkg::DivisorW'(trial - {1'b0, div_q})
                  : shsq_pkg::DivisorW'(trial);
      quot_d = {quot_q[shsq_pkg::QuotW-2:0], ge};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CntLast) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q  <= div_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[hdl/stepper_half_step_job_sequencer_unit.sv]
// Ticks, stops, rejected and other requests without division are registered
// into the output register. A start at or above the threshold runs the serial
// divider: one quotient bit per cycle over 14 bits, plus load and finish.
// One request per cycle, but not under output stall nor while a division runs.
// Reset: job cleared, half_step_wait 2, speed_threshold 100, no clearing pass.
// Top level; depends on shsq_pkg and shsq_div.
`timescale 1ns / 1ps

module stepper_half_step_job_sequencer_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  shsq_pkg::req_t                  in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output shsq_pkg::res_t                  out_res_o,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [shsq_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  shsq_pkg::state_e                state_q, state_d;
  shsq_pkg::dir_e                  dir_q, dir_d;
  logic [3:0]                      phase_q, phase_d;
  logic [shsq_pkg::HswW-1:0]       swait_q, swait_d;
  logic [shsq_pkg::DelayW-1:0]     cdelay_q, cdelay_d;
  logic [shsq_pkg::DelayW-1:0]     ccount_q, ccount_d;
  logic [15:0]                     cleft_q, cleft_d;
  logic [shsq_pkg::HswW-1:0]       hsw_q;
  logic [shsq_pkg::ThrW-1:0]       thr_q;
  logic                            out_valid_q, out_valid_d;
  shsq_pkg::res_t                  out_res_q, out_res_d;

  logic                            accept;
  logic                            neg;
  logic [15:0]                     mag;
  logic                            start_ok;
  logic                            div_start;
  logic                            div_done;
  logic [shsq_pkg::DivisorW-1:0]   divisor;
  logic [shsq_pkg::QuotW-1:0]      quot;
  logic [shsq_pkg::DelayW-1:0]     delay_sat;
  logic [shsq_pkg::DelayW-1:0]     delay_fl;
  logic [shsq_pkg::DelayW-1:0]     hsw_ext;

  assign in_stall_o = (state_q != shsq_pkg::ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  assign neg      = in_req_i.speed[15];
  assign mag      = neg ? 16'(~in_req_i.speed + 16'sd1) : 16'(in_req_i.speed);
  assign start_ok = (mag >= {1'b0, thr_q}) && (mag != 16'd0);
  assign divisor  = {1'b0, mag} + {{(shsq_pkg::DivisorW-shsq_pkg::HswW){1'b0}}, hsw_q};
  assign div_start = accept && (in_req_i.func == shsq_pkg::FUNC_START)
                     && (dir_q == shsq_pkg::DIR_STOP) && start_ok;

  shsq_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (divisor),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  assign hsw_ext   = {{(shsq_pkg::DelayW-shsq_pkg::HswW){1'b0}}, hsw_q};
  assign delay_sat = (quot > {1'b0, shsq_pkg::DelayMax}) ? shsq_pkg::DelayMax
                                                         : quot[shsq_pkg::DelayW-1:0];
  assign delay_fl  = (delay_sat < hsw_ext) ? hsw_ext : delay_sat;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      shsq_pkg::ST_IDLE: begin
        if (div_start) state_d = shsq_pkg::ST_DIV;
      end
      shsq_pkg::ST_DIV: begin
        if (div_done) state_d = shsq_pkg::ST_IDLE;
      end
      default: state_d = shsq_pkg::ST_IDLE;
    endcase
  end

  // job datapath and result
  always_comb begin
    dir_d       = dir_q;
    phase_d     = phase_q;
    swait_d     = swait_q;
    cdelay_d    = cdelay_q;
    ccount_d    = ccount_q;
    cleft_d     = cleft_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_res_d   = out_res_q;

    if (div_done) begin
      cdelay_d    = delay_fl;
      ccount_d    = delay_fl;
      swait_d     = '0;
      phase_d     = (dir_q == shsq_pkg::DIR_REV) ? shsq_pkg::PhaseLast : 4'd0;
      out_valid_d = 1'b1;
      out_res_d   = '{coil_pattern: 4'd0, coil_update: 1'b0, busy_res: 1'b1,
                      rejected: 1'b0};
    end else if (accept) begin
      out_res_d = '{coil_pattern: 4'd0, coil_update: 1'b0, busy_res: 1'b0,
                    rejected: 1'b0};
      case (in_req_i.func)
        shsq_pkg::FUNC_TICK: begin
          if (dir_q != shsq_pkg::DIR_FWD && dir_q != shsq_pkg::DIR_REV) begin
            dir_d = shsq_pkg::DIR_STOP;
          end else if (swait_q != '0) begin
            swait_d = swait_q - 1'b1;
          end else if (!phase_q[3]) begin
            out_res_d.coil_pattern = shsq_pkg::pattern(phase_q[2:0]);
            out_res_d.coil_update  = 1'b1;
            swait_d = hsw_q;
            if (dir_q == shsq_pkg::DIR_FWD) begin
              phase_d = (phase_q == shsq_pkg::PhaseLast) ? shsq_pkg::PhaseNone
                                                         : phase_q + 4'd1;
            end else begin
              phase_d = (phase_q == 4'd0) ? shsq_pkg::PhaseNone : phase_q - 4'd1;
            end
            if (phase_d == shsq_pkg::PhaseNone) ccount_d = cdelay_q;
          end else if (ccount_q != '0) begin
            ccount_d = ccount_q - 1'b1;
          end else if (cleft_q != '0) begin
            cleft_d  = cleft_q - 16'd1;
            phase_d  = (dir_q == shsq_pkg::DIR_REV) ? shsq_pkg::PhaseLast : 4'd0;
            ccount_d = cdelay_q;
            swait_d  = hsw_q;
          end else begin
            dir_d = shsq_pkg::DIR_STOP;
          end
        end
        shsq_pkg::FUNC_START: begin
          if (dir_q != shsq_pkg::DIR_STOP) begin
            out_res_d.rejected = 1'b1;
          end else if (start_ok) begin
            dir_d   = neg ? shsq_pkg::DIR_REV : shsq_pkg::DIR_FWD;
            cleft_d = in_req_i.distance;
          end else begin
            dir_d    = shsq_pkg::DIR_STOP;
            phase_d  = shsq_pkg::PhaseNone;
            swait_d  = '0;
            cdelay_d = '0;
            ccount_d = '0;
            cleft_d  = '0;
          end
        end
        shsq_pkg::FUNC_STOP: begin
          dir_d    = shsq_pkg::DIR_STOP;
          phase_d  = shsq_pkg::PhaseNone;
          swait_d  = '0;
          cdelay_d = '0;
          ccount_d = '0;
          cleft_d  = '0;
        end
        default: ;
      endcase
      out_res_d.busy_res = (dir_d != shsq_pkg::DIR_STOP);
      out_valid_d        = !div_start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= shsq_pkg::ST_IDLE;
      dir_q       <= shsq_pkg::DIR_STOP;
      phase_q     <= shsq_pkg::PhaseNone;
      swait_q     <= '0;
      cdelay_q    <= '0;
      ccount_q    <= '0;
      cleft_q     <= '0;
      out_valid_q <= 1'b0;
      hsw_q       <= shsq_pkg::HswReset;
      thr_q       <= shsq_pkg::ThrReset;
    end else begin
      state_q     <= state_d;
      dir_q       <= dir_d;
      phase_q     <= phase_d;
      swait_q     <= swait_d;
      cdelay_q    <= cdelay_d;
      ccount_q    <= ccount_d;
      cleft_q     <= cleft_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          shsq_pkg::CFG_HALF_STEP_WAIT:  hsw_q <= cfg_wdata_i[shsq_pkg::HswW-1:0];
          shsq_pkg::CFG_SPEED_THRESHOLD: thr_q <= cfg_wdata_i[shsq_pkg::ThrW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> state_q == shsq_pkg::ST_IDLE)
    else $error("request taken outside idle");

  a_div_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == shsq_pkg::ST_DIV |-> !out_valid_q)
    else $error("result pending during division");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == shsq_pkg::ST_DIV)
    else $error("divider done outside division");

  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.coil_update |-> out_res_o.busy_res)
    else $error("coil driven while idle");

  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> dir_q != shsq_pkg::DIR_STOP)
    else $error("accepted start left no direction");

endmodule

[test/tb_top.sv]
// tb_top: self-checking bench for stepper_half_step_job_sequencer_unit. A behavioural
// model of the half-step sequencer predicts every result; directed and random jobs.
// Depends on shsq_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0]  FuncSpare   = 2'd3;
  localparam logic [31:0] HalfStepLut = {4'h9, 4'h8, 4'hc, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1};
  localparam int          SettleCyc   = 24;
  localparam int          SatTicks    = 40;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  shsq_pkg::req_t                in_req_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  shsq_pkg::res_t                out_res_o;
  logic                          cfg_we_i;
  logic                          cfg_idx_i;
  logic [shsq_pkg::CfgDataW-1:0] cfg_wdata_i;

  // sequencer model state
  logic [shsq_pkg::HswW-1:0]   seq_hsw;
  logic [shsq_pkg::ThrW-1:0]   seq_thr;
  shsq_pkg::dir_e              seq_dir;
  logic [3:0]                  seq_phase;
  logic [shsq_pkg::HswW-1:0]   seq_wait;
  logic [shsq_pkg::DelayW-1:0] seq_delay;
  logic [shsq_pkg::DelayW-1:0] seq_delay_cnt;
  logic [15:0]                 seq_left;

  shsq_pkg::res_t coil_res_q[$];
  int             fail_cnt;
  bit             calm;

  stepper_half_step_job_sequencer_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic void drop_job();
    seq_dir       = shsq_pkg::DIR_STOP;
    seq_phase     = shsq_pkg::PhaseNone;
    seq_wait      = '0;
    seq_delay     = '0;
    seq_delay_cnt = '0;
    seq_left      = '0;
  endfunction

  function automatic shsq_pkg::res_t step_sequencer(shsq_pkg::req_t r);
    shsq_pkg::res_t o;
    int unsigned    mag;
    int unsigned    quot;
    o = '0;
    case (r.func)
      shsq_pkg::FUNC_TICK: begin
        if (seq_dir != shsq_pkg::DIR_FWD && seq_dir != shsq_pkg::DIR_REV) begin
          seq_dir = shsq_pkg::DIR_STOP;
        end else if (seq_wait != 0) begin
          seq_wait = seq_wait - 1'b1;
        end else if (!seq_phase[3]) begin
          o.coil_update  = 1'b1;
          o.coil_pattern = HalfStepLut[{seq_phase[2:0], 2'b00} +: 4];
          seq_wait       = seq_hsw;
          if (seq_dir == shsq_pkg::DIR_FWD) begin
            seq_phase = (seq_phase == shsq_pkg::PhaseLast) ? shsq_pkg::PhaseNone
                                                           : seq_phase + 1'b1;
          end else begin
            seq_phase = (seq_phase == 4'd0) ? shsq_pkg::PhaseNone : seq_phase - 1'b1;
          end
          if (seq_phase == shsq_pkg::PhaseNone) seq_delay_cnt = seq_delay;
        end else if (seq_delay_cnt != 0) begin
          seq_delay_cnt = seq_delay_cnt - 1'b1;
        end else if (seq_left != 0) begin
          seq_left      = seq_left - 1'b1;
          seq_phase     = (seq_dir == shsq_pkg::DIR_REV) ? shsq_pkg::PhaseLast : 4'd0;
          seq_delay_cnt = seq_delay;
          seq_wait      = seq_hsw;
        end else begin
          seq_dir = shsq_pkg::DIR_STOP;
        end
      end
      shsq_pkg::FUNC_START: begin
        if (seq_dir != shsq_pkg::DIR_STOP) begin
          o.rejected = 1'b1;
        end else begin
          mag = r.speed[15] ? 32'h10000 - r.speed[15:0] : r.speed[15:0];
          if (mag < seq_thr || mag == 0) begin
            drop_job();
          end else begin
            seq_dir = r.speed[15] ? shsq_pkg::DIR_REV : shsq_pkg::DIR_FWD;
            quot    = shsq_pkg::Dividend / (mag + seq_hsw);
            if (quot > shsq_pkg::DelayMax) quot = shsq_pkg::DelayMax;
            if (quot < seq_hsw) quot = seq_hsw;
            seq_delay     = quot[shsq_pkg::DelayW-1:0];
            seq_delay_cnt = quot[shsq_pkg::DelayW-1:0];
            seq_wait      = '0;
            seq_left      = r.distance;
            seq_phase     = r.speed[15] ? shsq_pkg::PhaseLast : 4'd0;
          end
        end
      end
      shsq_pkg::FUNC_STOP: drop_job();
      default: ;
    endcase
    o.busy_res = (seq_dir != shsq_pkg::DIR_STOP);
    return o;
  endfunction

  function automatic shsq_pkg::req_t mk_req(logic [1:0] f, logic signed [15:0] s,
                                            logic [15:0] d);
    shsq_pkg::req_t r;
    r.func     = f;
    r.speed    = s;
    r.distance = d;
    return r;
  endfunction

  function automatic logic signed [15:0] rand_speed(bit reach);
    int unsigned        m;
    logic signed [15:0] s;
    if (reach) begin
      if ($urandom_range(49) == 0) return 16'sh8000;
      m = $urandom_range(32767, (seq_thr == 0) ? 1 : seq_thr);
    end else begin
      m = (seq_thr == 0) ? 0 : $urandom_range(seq_thr - 1, 0);
    end
    s = m[15:0];
    if ($urandom_range(1)) s = -s;
    return s;
  endfunction

  // sends one request; called at a rising edge, returns at the edge of acceptance
  task automatic issue_req(shsq_pkg::req_t r);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 10) gap = $urandom_range(4, 1);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
    coil_res_q.push_back(step_sequencer(r));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (coil_res_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(shsq_pkg::cfg_e idx, logic [shsq_pkg::CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == shsq_pkg::CFG_HALF_STEP_WAIT) seq_hsw = val[shsq_pkg::HswW-1:0];
    else seq_thr = val[shsq_pkg::ThrW-1:0];
  endtask

  task automatic configure(int hsw, int thr);
    settle();
    write_reg(shsq_pkg::CFG_HALF_STEP_WAIT, shsq_pkg::CfgDataW'(hsw));
    write_reg(shsq_pkg::CFG_SPEED_THRESHOLD, shsq_pkg::CfgDataW'(thr));
  endtask

  // reset values: threshold 100 and two wait ticks after each half-step
  task automatic test_reset_defaults();
    issue_req(mk_req(shsq_pkg::FUNC_START, 16'sd99, 16'd0));
    issue_req(mk_req(shsq_pkg::FUNC_START, 16'sd100, 16'd0));
    repeat (5) issue_req(mk_req(shsq_pkg::FUNC_TICK, 16'sd0, 16'd0));
    issue_req(mk_req(shsq_pkg::FUNC_STOP, 16'sd0, 16'd0));
  endtask

  task automatic test_directed();
    configure(1, 5000);
    issue_req(mk_req(shsq_pkg::FUNC_TICK, 16'sd0, 16'd0));
    issue_req(mk_req(shsq_pkg::FUNC_STOP, -16'sd1, 16'hffff));
    issue_req(mk_req(FuncSpare, 16'sd5000, 16'd3));
    issue_req(mk_req(shsq_pkg::FUNC_START, 16'sd4999, 16'd0));
    issue_req(mk_req(shsq_pkg::FUNC_START, 16'sd32767, 16'd0));
    issue_req(mk_req(shsq_pkg::FUNC_START, -16'sd32767, 16'd2));
    issue_req(mk_req(FuncSpare, 16'sd0, 16'd0));
    while (seq_dir != shsq_pkg::DIR_STOP)
      issue_req(mk_req(shsq_pkg::FUNC_TICK, 16'sd0, 16'd0));
    issue_req(mk_req(shsq_pkg::FUNC_START, 16'sh8000, 16'd1));
    repeat (6) issue_req(mk_req(shsq_pkg::FUNC_TICK, 16'sh7fff, 16'hffff));
    issue_req(mk_req(shsq_pkg::FUNC_STOP, 16'sd0, 16'd0));
    issue_req(mk_req(shsq_pkg::FUNC_START, -16'sd5000, 16'hffff));
    issue_req(mk_req(shsq_pkg::FUNC_TICK, 16'sd0, 16'd0));
    issue_req(mk_req(shsq_pkg::FUNC_STOP, 16'sd0, 16'd0));
  endtask

  // zero wait with a speed of one gives a tick delay beyond the 13-bit range;
  // the pass is driven, then the long delay is cut short by a stop
  task automatic test_delay_saturation();
    configure(0, 0);
    issue_req(mk_req(shsq_pkg::FUNC_START, 16'sd0, 16'd0));
    settle();
    write_reg(shsq_pkg::CFG_SPEED_THRESHOLD, shsq_pkg::CfgDataW'(1));
    calm = 1'b1;
    issue_req(mk_req(shsq_pkg::FUNC_START, 16'sd1, 16'd0));
    repeat (SatTicks) issue_req(mk_req(shsq_pkg::FUNC_TICK, 16'sd0, 16'd0));
    issue_req(mk_req(shsq_pkg::FUNC_STOP, 16'sd0, 16'd0));
    calm = 1'b0;
  endtask

  task automatic test_random_jobs(int n_items, int hsw, int thr, bit quiet);
    int             k;
    int             pick;
    shsq_pkg::req_t r;
    configure(hsw, thr);
    calm = quiet;
    for (k = 0; k < n_items; k++) begin
      pick = $urandom_range(99);
      r    = mk_req(shsq_pkg::FUNC_TICK, 16'($urandom_range(16'hffff)),
                    16'($urandom_range(16'hffff)));
      if (seq_dir == shsq_pkg::DIR_STOP) begin
        if (pick < 75) begin
          r.func     = shsq_pkg::FUNC_START;
          r.speed    = rand_speed(1'b1);
          r.distance = ($urandom_range(9) != 0) ? 16'($urandom_range(2))
                                                : 16'($urandom_range(16'hffff));
        end else if (pick < 85) begin
          r.func  = shsq_pkg::FUNC_START;
          r.speed = rand_speed(1'b0);
        end else begin
          r.func = (pick < 90) ? shsq_pkg::FUNC_TICK :
                   (pick < 95) ? shsq_pkg::FUNC_STOP : FuncSpare;
        end
      end else begin
        if (pick >= 96) r.func = FuncSpare;
        else if (pick >= 92) r.func = shsq_pkg::FUNC_START;
        else if (pick >= 88) r.func = shsq_pkg::FUNC_STOP;
      end
      issue_req(r);
    end
    calm = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (coil_res_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_res_o);
        fail_cnt++;
      end else begin
        shsq_pkg::res_t e;
        e = coil_res_q.pop_front();
        if (out_res_o.coil_pattern !== e.coil_pattern) begin
          $display("%0t: coil_pattern expected %h got %h", $time, e.coil_pattern,
                   out_res_o.coil_pattern);
          fail_cnt++;
        end
        if (out_res_o.coil_update !== e.coil_update) begin
          $display("%0t: coil_update expected %b got %b", $time, e.coil_update,
                   out_res_o.coil_update);
          fail_cnt++;
        end
        if (out_res_o.busy_res !== e.busy_res) begin
          $display("%0t: busy_res expected %b got %b", $time, e.busy_res, out_res_o.busy_res);
          fail_cnt++;
        end
        if (out_res_o.rejected !== e.rejected) begin
          $display("%0t: rejected expected %b got %b", $time, e.rejected, out_res_o.rejected);
          fail_cnt++;
        end
      end
    end
    out_stall_i <= !calm && ($urandom_range(99) < 10);
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = shsq_pkg::CFG_HALF_STEP_WAIT;
    cfg_wdata_i = '0;
    calm        = 1'b0;
    fail_cnt    = 0;
    seq_hsw     = shsq_pkg::HswReset;
    seq_thr     = shsq_pkg::ThrReset;
    drop_job();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_directed();
    test_delay_saturation();
    test_random_jobs(130, 1, 1, 1'b0);
    test_random_jobs(150, 2, 100, 1'b1);
    test_random_jobs(40, 1023, 32767, 1'b0);
    test_random_jobs(130, 3, $urandom_range(2000, 200), 1'b0);
    test_random_jobs(130, $urandom_range(6, 1), $urandom_range(32767, 1), 1'b0);
    test_random_jobs(120, 1, $urandom_range(8000, 500), 1'b0);
    settle();

    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/shsq_pkg.sv
hdl/shsq_div.sv
hdl/stepper_half_step_job_sequencer_unit.sv
test/tb_top.sv
